// File: sv/liferle_pkg.sv
// ----------------------------------------------------------------------------
// liferle_pkg - shared types and constants for the RLE run decoder
// Character codes, field widths, limits and the result beat structure.
// ----------------------------------------------------------------------------
package liferle_pkg;

  // Field widths
  localparam int CHAR_W  = 8;
  localparam int WIDTH_W = 11;
  localparam int CNT_W   = 16;
  localparam int POS_W   = 16;
  localparam int LEN_W   = 27;

  // Widest line the decoder honors; larger widths are clamped to this
  localparam logic [WIDTH_W-1:0] MAX_WIDTH   = 11'd1024;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 11'd64;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'd57;
  localparam logic [CHAR_W-1:0] CHAR_DEAD = 8'h62;  // 'b'
  localparam logic [CHAR_W-1:0] CHAR_LIVE = 8'h6F;  // 'o'
  localparam logic [CHAR_W-1:0] CHAR_EOL  = 8'h24;  // '$'
  localparam logic [CHAR_W-1:0] CHAR_END  = 8'h21;  // '!'

  // Saturation limits
  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;
  localparam logic [POS_W-1:0] POS_MAX = 16'hFFFF;

  // One result beat
  typedef struct packed {
    logic             cell_alive;
    logic [LEN_W-1:0] run_length;
    logic             line_end_run;
    logic             pattern_end;
    logic             line_overrun;
  } result_t;

endpackage

// File: sv/liferle_in_reg.sv
// ----------------------------------------------------------------------------
// liferle_in_reg - input character register
// Holds one accepted character until the decode stage consumes it.
// ----------------------------------------------------------------------------
module liferle_in_reg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [liferle_pkg::CHAR_W-1:0]  char_code,
  input  logic                            take,
  output logic                            held_valid,
  output logic [liferle_pkg::CHAR_W-1:0]  held_char
);

  // Room when empty or when the held beat leaves this cycle
  assign in_ready = !held_valid || take;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_char <= char_code;
    end
  end

endmodule

// File: sv/liferle_core.sv
// ----------------------------------------------------------------------------
// liferle_core - character decode and line state
// Holds the repeat count, line position and width register; turns one
// character into a run beat and the next state combinationally.
// ----------------------------------------------------------------------------
module liferle_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [liferle_pkg::WIDTH_W-1:0]  cfg_wr_data,
  input  logic                             held_valid,
  input  logic [liferle_pkg::CHAR_W-1:0]   held_char,
  input  logic                             out_free,
  output logic                             take,
  output logic                             res_load,
  output liferle_pkg::result_t             res
);

  logic [liferle_pkg::WIDTH_W-1:0] line_width;
  logic [liferle_pkg::CNT_W-1:0]   repeat_count;
  logic [liferle_pkg::CNT_W-1:0]   repeat_count_next;
  logic [liferle_pkg::POS_W-1:0]   line_position;
  logic [liferle_pkg::POS_W-1:0]   line_position_next;

  logic                            is_digit;
  logic                            is_run;
  logic                            is_pad;
  logic                            has_result;
  logic [19:0]                     cnt_sum;
  logic [liferle_pkg::CNT_W-1:0]   run_n;
  logic [liferle_pkg::POS_W:0]     pos_sum;
  logic [liferle_pkg::WIDTH_W-1:0] width_use;
  logic [liferle_pkg::LEN_W-1:0]   pad_total;
  logic [liferle_pkg::LEN_W-1:0]   pos_ext;

  // Width register
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= liferle_pkg::WIDTH_RESET;
    end else if (cfg_wr_en) begin
      line_width <= cfg_wr_data;
    end
  end

  // Character class
  assign is_digit = (held_char >= liferle_pkg::CHAR_ZERO) &&
                    (held_char <= liferle_pkg::CHAR_NINE);
  assign is_run   = (held_char == liferle_pkg::CHAR_DEAD) ||
                    (held_char == liferle_pkg::CHAR_LIVE);
  assign is_pad   = (held_char == liferle_pkg::CHAR_EOL) ||
                    (held_char == liferle_pkg::CHAR_END);
  assign has_result = is_run || is_pad;

  // Beats with no result never wait on the output side
  assign take     = held_valid && (!has_result || out_free);
  assign res_load = take && has_result;

  // Count * 10 + digit; the low nibble of '0'..'9' is the digit
  assign cnt_sum = ({4'b0, repeat_count} << 3) + ({4'b0, repeat_count} << 1) +
                   {16'b0, held_char[3:0]};

  // Run length: missing count means one
  assign run_n   = (repeat_count == '0) ? 16'd1 : repeat_count;
  assign pos_sum = {1'b0, line_position} + {1'b0, run_n};

  // Padding: width * max(count,1) - position, floored at zero
  assign width_use = (line_width > liferle_pkg::MAX_WIDTH) ?
                     liferle_pkg::MAX_WIDTH : line_width;
  assign pad_total = {16'b0, width_use} * {11'b0, run_n};
  assign pos_ext   = {11'b0, line_position};

  // Result beat
  always_comb begin
    res.cell_alive   = 1'b0;
    res.run_length   = '0;
    res.line_end_run = 1'b0;
    res.pattern_end  = 1'b0;
    res.line_overrun = 1'b0;
    if (is_run) begin
      res.cell_alive = (held_char == liferle_pkg::CHAR_LIVE);
      res.run_length = {11'b0, run_n};
    end else if (is_pad) begin
      res.run_length   = (pad_total > pos_ext) ? (pad_total - pos_ext) : '0;
      res.line_end_run = 1'b1;
      res.pattern_end  = (held_char == liferle_pkg::CHAR_END);
      res.line_overrun = (line_position > {5'b0, width_use});
    end
  end

  // Next state
  always_comb begin
    repeat_count_next  = repeat_count;
    line_position_next = line_position;
    if (is_digit) begin
      repeat_count_next = (cnt_sum > {4'b0, liferle_pkg::CNT_MAX}) ?
                          liferle_pkg::CNT_MAX : cnt_sum[15:0];
    end else if (is_run) begin
      repeat_count_next  = '0;
      line_position_next = pos_sum[16] ? liferle_pkg::POS_MAX : pos_sum[15:0];
    end else if (is_pad) begin
      repeat_count_next  = '0;
      line_position_next = '0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_count  <= '0;
      line_position <= '0;
    end else if (take) begin
      repeat_count  <= repeat_count_next;
      line_position <= line_position_next;
    end
  end

endmodule

// File: sv/liferle_out_reg.sv
// ----------------------------------------------------------------------------
// liferle_out_reg - result register
// Holds one run beat for the consumer; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module liferle_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 res_load,
  input  liferle_pkg::result_t res,
  output logic                 out_free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output liferle_pkg::result_t held_res
);

  assign out_free = !out_valid || out_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_load;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (res_load) begin
      held_res <= res;
    end
  end

endmodule

// File: sv/life_rle_run_decoder_unit.sv
// ----------------------------------------------------------------------------
// life_rle_run_decoder_unit - RLE pattern body run decoder
// Decodes pattern body characters into live, dead and line padding runs.
// ----------------------------------------------------------------------------
// Accepts one character per clock unless a run or line character is held
// waiting for room in the result register, and emits at most one run beat
// per character. A character is first held in the input register while the
// decode logic updates the repeat count and line position, and the result
// register loads its beat once it has room. The rate is set by that single
// decode step, which carries the count and position from one character to
// the next. Digits, and characters that are not run or line codes, produce
// no beat. A width write takes effect for characters decoded from the next
// cycle on; widths above 1024 are clamped to 1024.
// ----------------------------------------------------------------------------
module life_rle_run_decoder_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [liferle_pkg::WIDTH_W-1:0]      cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [liferle_pkg::CHAR_W-1:0]       char_code,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 cell_alive,
  output logic [liferle_pkg::LEN_W-1:0]        run_length,
  output logic                                 line_end_run,
  output logic                                 pattern_end,
  output logic                                 line_overrun
);

  logic                           held_valid;
  logic [liferle_pkg::CHAR_W-1:0] held_char;
  logic                           take;
  logic                           res_load;
  logic                           out_free;
  liferle_pkg::result_t           res;
  liferle_pkg::result_t           held_res;

  // Input character register
  liferle_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_code  (char_code),
    .take       (take),
    .held_valid (held_valid),
    .held_char  (held_char)
  );

  // Decode and line state
  liferle_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .held_valid  (held_valid),
    .held_char   (held_char),
    .out_free    (out_free),
    .take        (take),
    .res_load    (res_load),
    .res         (res)
  );

  // Result register
  liferle_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_load  (res_load),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .held_res  (held_res)
  );

  assign cell_alive   = held_res.cell_alive;
  assign run_length   = held_res.run_length;
  assign line_end_run = held_res.line_end_run;
  assign pattern_end  = held_res.pattern_end;
  assign line_overrun = held_res.line_overrun;

endmodule

// File: sv/liferle_checker.sv
// ----------------------------------------------------------------------------
// liferle_checker - port-level checks for the RLE run decoder
// Watches the top-level ports and flags inconsistent run beats.
// ----------------------------------------------------------------------------
module liferle_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          cell_alive,
  input logic [liferle_pkg::LEN_W-1:0] run_length,
  input logic                          line_end_run,
  input logic                          pattern_end,
  input logic                          line_overrun
);

  // A stalled beat stays valid and holds its length, line-end and cell fields
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(run_length) &&
    $stable(line_end_run) && $stable(cell_alive))
    else $error("output beat changed while stalled");

  // End marker and overrun flags only on padding runs
  a_flags_pad: assert property (@(posedge clk) disable iff (rst)
    out_valid && !line_end_run |-> !pattern_end && !line_overrun)
    else $error("pad-only flag on a cell run");

  // Padding is always dead
  a_pad_dead: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_end_run |-> !cell_alive)
    else $error("live padding run");

  // Cell runs hold at least one cell and at most a full count
  a_run_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && !line_end_run |-> (run_length != '0) && (run_length[26:16] == '0))
    else $error("cell run length out of range");

endmodule

bind life_rle_run_decoder_unit liferle_checker u_liferle_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .cell_alive   (cell_alive),
  .run_length   (run_length),
  .line_end_run (line_end_run),
  .pattern_end  (pattern_end),
  .line_overrun (line_overrun)
);
